// ===== rtl/lut3d_pkg.sv =====
// ============================================================================
// lut3d_pkg - shared types and constants for the 3D LUT blend unit
// Channel widths, configuration layout, queue word format and the
// rounded linear mix used by every interpolation and blend step.
// ============================================================================
`default_nettype none

package lut3d_pkg;

  // Field widths.
  localparam int CHAN_W    = 16;
  localparam int NUM_CH    = 3;
  localparam int IDX_W     = 16;
  localparam int SIZE_W    = 6;
  localparam int STR_W     = 17;
  localparam int DOM_W     = 48;
  localparam int Q16_W     = 17;
  localparam int CFG_IDX_W = 3;

  localparam int MAX_LUT_POINTS_DEF = 33;

  // Arithmetic constants.
  localparam logic [Q16_W-1:0]  ONE_Q16      = 17'h10000;
  localparam logic [CHAN_W-1:0] MIN_DENOM    = 16'd7;
  localparam logic [STR_W-1:0]  MIN_STRENGTH = 17'd6;
  localparam logic [SIZE_W-1:0] MIN_POINTS   = 6'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LUT_ENABLE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LUT_SIZE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_STRENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_LOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DOMAIN_HIGH    = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [SIZE_W-1:0] SIZE_RST     = 6'd33;
  localparam logic [STR_W-1:0]  STRENGTH_RST = 17'h10000;
  localparam logic [DOM_W-1:0]  DOM_HIGH_RST = 48'hFFFF_FFFF_FFFF;

  // Request type code for a pixel word.
  localparam logic REQ_PIXEL = 1'b1;

  typedef logic [CHAN_W-1:0] chan_t;
  // Index 0 is red, 1 green, 2 blue, matching the domain register packing.
  typedef chan_t [NUM_CH-1:0] rgb_t;

  typedef struct packed {
    logic                en;
    logic [SIZE_W-1:0]   size;
    logic [STR_W-1:0]    strength;
    logic [DOM_W-1:0]    dom_lo;
    logic [DOM_W-1:0]    dom_hi;
  } cfg_t;

  // Classified word handed from the front to the back.
  typedef struct packed {
    logic              is_pix;
    logic              bypass;
    logic              load_ok;
    logic [IDX_W-1:0]  idx;
    rgb_t              pix;
    rgb_t              num;
    rgb_t              den;
    logic [NUM_CH-1:0] sat;
  } qent_t;

  // Rounded mix: (a*(1-w) + b*w + 0.5) >> 16, written as a + ((b-a)*w + 0.5) >> 16.
  function automatic chan_t mix(input chan_t a, input chan_t b, input logic [Q16_W-1:0] w);
    logic signed [CHAN_W:0]     d;
    logic signed [2*CHAN_W+2:0] p;
    logic [CHAN_W+2:0]          s;
    d = $signed({1'b0, b}) - $signed({1'b0, a});
    p = d * $signed({1'b0, w}) + 35'sd32768;
    s = {3'b000, a} + p[2*CHAN_W+2:CHAN_W];
    return s[CHAN_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lut3d_front.sv =====
// ============================================================================
// lut3d_front - word classification and domain normalization setup
// Sorts each incoming word into load, mapped pixel or pass-through pixel and
// prepares the per-channel numerator, denominator and saturation flag.
// ============================================================================
`default_nettype none

module lut3d_front #(
  parameter int MAX_LUT_POINTS = lut3d_pkg::MAX_LUT_POINTS_DEF
) (
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic                     in_req_type,
  input  wire logic [lut3d_pkg::IDX_W-1:0]  in_entry_index,
  input  wire logic [lut3d_pkg::CHAN_W-1:0] in_chan_red,
  input  wire logic [lut3d_pkg::CHAN_W-1:0] in_chan_green,
  input  wire logic [lut3d_pkg::CHAN_W-1:0] in_chan_blue,
  input  wire lut3d_pkg::cfg_t          cfg,
  input  wire logic                     q_full,
  output logic                          push,
  output lut3d_pkg::qent_t              push_data
);
  import lut3d_pkg::*;

  localparam int CUBE_DEPTH = MAX_LUT_POINTS * MAX_LUT_POINTS * MAX_LUT_POINTS;

  rgb_t pix;
  rgb_t lo;
  rgb_t hi;
  rgb_t span;

  assign pix = {in_chan_blue, in_chan_green, in_chan_red};
  assign lo  = rgb_t'(cfg.dom_lo);
  assign hi  = rgb_t'(cfg.dom_hi);

  // Per channel: floored denominator, offset from the domain minimum.
  always_comb begin
    push_data.is_pix  = (in_req_type == REQ_PIXEL);
    push_data.bypass  = !cfg.en || (cfg.strength <= MIN_STRENGTH) ||
                        (cfg.size < MIN_POINTS) || (32'(cfg.size) > MAX_LUT_POINTS);
    push_data.load_ok = (32'(in_entry_index) < CUBE_DEPTH);
    push_data.idx     = in_entry_index;
    push_data.pix     = pix;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      span[ch]          = hi[ch] - lo[ch];
      push_data.den[ch] = ((hi[ch] > lo[ch]) && (span[ch] >= MIN_DENOM)) ? span[ch] : MIN_DENOM;
      push_data.num[ch] = (pix[ch] > lo[ch]) ? (pix[ch] - lo[ch]) : '0;
      push_data.sat[ch] = (push_data.num[ch] >= push_data.den[ch]);
    end
  end

  // Take a word whenever the queue has room.
  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

endmodule

`default_nettype wire

// ===== rtl/lut3d_queue.sv =====
// ============================================================================
// lut3d_queue - two-word queue between front and back
// Lets the front keep taking words while the back stalls, until both entries are full.
// ============================================================================
`default_nettype none

module lut3d_queue (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire lut3d_pkg::qent_t push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output lut3d_pkg::qent_t      head_data
);
  import lut3d_pkg::*;

  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  qent_t              entry_r [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  assign full       = (cnt_r == CNT_W'(QDEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_data  = entry_r[rd_ptr_r];

endmodule

`default_nettype wire

// ===== rtl/lut3d_div.sv =====
// ============================================================================
// lut3d_div - pipelined restoring divider for one channel
// Computes (num << 16) / den for num < den, one quotient bit per stage.
// ============================================================================
`default_nettype none

module lut3d_div (
  input  wire logic                         clk,
  input  wire logic                         adv,
  input  wire logic [lut3d_pkg::CHAN_W-1:0] num,
  input  wire logic [lut3d_pkg::CHAN_W-1:0] den,
  output logic [lut3d_pkg::CHAN_W-1:0]      quo
);
  import lut3d_pkg::*;

  localparam int STAGES = CHAN_W;

  chan_t rem_r [STAGES-1];
  chan_t den_r [STAGES-1];
  chan_t quo_r [STAGES];

  genvar k;
  for (k = 0; k < STAGES; k++) begin : g_stage
    chan_t             r_in;
    chan_t             d_in;
    chan_t             q_in;
    logic [CHAN_W:0]   r2;
    logic              ge;

    if (k == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[k-1];
      assign d_in = den_r[k-1];
      assign q_in = quo_r[k-1];
    end

    // One trial subtraction per stage.
    assign r2 = {r_in, 1'b0};
    assign ge = (r2 >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (adv) begin
        quo_r[k] <= {q_in[CHAN_W-2:0], ge};
      end
    end

    if (k < STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= ge ? CHAN_W'(r2 - {1'b0, d_in}) : CHAN_W'(r2);
          den_r[k] <= d_in;
        end
      end
    end
  end

  assign quo = quo_r[STAGES-1];

endmodule

`default_nettype wire

// ===== rtl/lut3d_back.sv =====
// ============================================================================
// lut3d_back - normalize, locate, fetch and interpolate
// Divider lanes, cube index math, eight replicated table copies (one per
// cube corner), three interpolation stages and the strength blend.
// ============================================================================
`default_nettype none

module lut3d_back #(
  parameter int MAX_LUT_POINTS = lut3d_pkg::MAX_LUT_POINTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire lut3d_pkg::cfg_t  cfg,
  input  wire logic             head_valid,
  input  wire lut3d_pkg::qent_t head_data,
  output logic                  pop,
  input  wire logic             out_ready,
  output logic                  out_valid,
  output lut3d_pkg::rgb_t       out_rgb
);
  import lut3d_pkg::*;

  localparam int CUBE_DEPTH = MAX_LUT_POINTS * MAX_LUT_POINTS * MAX_LUT_POINTS;
  localparam int ADDR_W     = $clog2(CUBE_DEPTH);
  localparam int DIV_LAT    = CHAN_W;
  localparam int NPIPE      = 8;
  localparam int NCORNER    = 8;
  localparam int S_W        = Q16_W + SIZE_W;
  localparam int BS_W       = 2 * SIZE_W;
  localparam int PROD_W     = 3 * SIZE_W;

  typedef struct packed {
    logic              is_pix;
    logic              bypass;
    logic              load_ok;
    logic [IDX_W-1:0]  idx;
    rgb_t              pix;
    logic [NUM_CH-1:0] sat;
    rgb_t              fr;
  } sb_t;

  logic                  adv;
  logic [SIZE_W-1:0]     size_m1;
  logic [Q16_W-1:0]      k_str;
  rgb_t                  quo;

  logic [DIV_LAT-1:0]    dv_r;
  sb_t                   dsb_r [DIV_LAT];
  logic [NPIPE-1:0]      pv_r;
  sb_t                   ps_r [NPIPE];

  logic [S_W-1:0]        s_r [NUM_CH];
  logic [SIZE_W-1:0]     clo_r [NUM_CH];
  logic [SIZE_W-1:0]     chi_r [NUM_CH];
  logic [BS_W-1:0]       bs_r [2];
  logic [PROD_W-1:0]     t_r [4];
  logic [SIZE_W-1:0]     r0_r;
  logic [SIZE_W-1:0]     r1_r;
  logic [ADDR_W-1:0]     addr_r [NCORNER];
  rgb_t                  rd_r [NCORNER];
  rgb_t                  l1_r [4];
  rgb_t                  l2_r [2];
  rgb_t                  m_r;
  rgb_t                  out_r;
  logic                  out_valid_r;

  logic [SIZE_W-1:0]     i0 [NUM_CH];
  logic [SIZE_W-1:0]     i1 [NUM_CH];
  logic [SIZE_W:0]       inc [NUM_CH];
  sb_t                   sb1_nxt;
  logic                  wr_en;

  // The whole back moves together; it stops only when the output is full.
  assign adv     = !out_valid_r || out_ready;
  assign pop     = adv && head_valid;
  assign size_m1 = cfg.size - 1'b1;
  assign k_str   = (cfg.strength > ONE_Q16) ? ONE_Q16 : cfg.strength;

  // Divider lanes, one per channel.
  genvar ch_g;
  for (ch_g = 0; ch_g < NUM_CH; ch_g++) begin : g_div
    lut3d_div u_div (
      .clk (clk),
      .adv (adv),
      .num (head_data.num[ch_g]),
      .den (head_data.den[ch_g]),
      .quo (quo[ch_g])
    );
  end

  // Valid bits for the divider and the following stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r        <= '0;
      pv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      dv_r        <= {dv_r[DIV_LAT-2:0], head_valid};
      pv_r        <= {pv_r[NPIPE-2:0], dv_r[DIV_LAT-1]};
      out_valid_r <= pv_r[NPIPE-1] && ps_r[NPIPE-1].is_pix;
    end
  end

  // Side information travels beside the divider.
  always_ff @(posedge clk) begin
    if (adv) begin
      dsb_r[0].is_pix  <= head_data.is_pix;
      dsb_r[0].bypass  <= head_data.bypass;
      dsb_r[0].load_ok <= head_data.load_ok;
      dsb_r[0].idx     <= head_data.idx;
      dsb_r[0].pix     <= head_data.pix;
      dsb_r[0].sat     <= head_data.sat;
      dsb_r[0].fr      <= '0;
      for (int k = 1; k < DIV_LAT; k++) begin
        dsb_r[k] <= dsb_r[k-1];
      end
    end
  end

  // Cube coordinates from the scaled position.
  always_comb begin
    sb1_nxt = ps_r[0];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      i0[ch]        = s_r[ch][Q16_W-1 +: SIZE_W];
      inc[ch]       = {1'b0, i0[ch]} + 1'b1;
      i1[ch]        = (inc[ch] < {1'b0, cfg.size}) ? inc[ch][SIZE_W-1:0] : size_m1;
      sb1_nxt.fr[ch] = s_r[ch][CHAN_W-1:0];
    end
  end

  // Scale, locate and address stages.
  always_ff @(posedge clk) begin
    if (adv) begin
      // Scale the normalized position by size - 1.
      ps_r[0] <= dsb_r[DIV_LAT-1];
      for (int ch = 0; ch < NUM_CH; ch++) begin
        s_r[ch] <= S_W'(dsb_r[DIV_LAT-1].sat[ch] ? ONE_Q16 : {1'b0, quo[ch]}) * S_W'(size_m1);
      end

      // Lower and upper coordinate per axis, blue row offsets.
      ps_r[1] <= sb1_nxt;
      for (int ch = 0; ch < NUM_CH; ch++) begin
        clo_r[ch] <= i0[ch];
        chi_r[ch] <= i1[ch];
      end
      bs_r[0] <= BS_W'(i0[2]) * BS_W'(cfg.size);
      bs_r[1] <= BS_W'(i1[2]) * BS_W'(cfg.size);

      // Plane offsets for the four blue and green combinations.
      ps_r[2] <= ps_r[1];
      for (int j = 0; j < 4; j++) begin
        t_r[j] <= (PROD_W'(bs_r[j / 2]) + PROD_W'((j % 2 == 1) ? chi_r[1] : clo_r[1])) *
                  PROD_W'(cfg.size);
      end
      r0_r <= clo_r[0];
      r1_r <= chi_r[0];

      // Corner addresses, bit 0 red, bit 1 green, bit 2 blue.
      ps_r[3] <= ps_r[2];
      for (int j = 0; j < NCORNER; j++) begin
        addr_r[j] <= ADDR_W'(t_r[j / 2] + PROD_W'((j % 2 == 1) ? r1_r : r0_r));
      end
    end
  end

  // A load writes all copies at the same stage where pixels read them.
  assign wr_en = adv && pv_r[3] && !ps_r[3].is_pix && ps_r[3].load_ok;

  genvar c_g;
  for (c_g = 0; c_g < NCORNER; c_g++) begin : g_copy
    rgb_t mem [CUBE_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        mem[ADDR_W'(ps_r[3].idx)] <= ps_r[3].pix;
      end
      if (adv) begin
        rd_r[c_g] <= mem[addr_r[c_g]];
      end
    end
  end

  // Interpolate along red, then green, then blue, then blend.
  always_ff @(posedge clk) begin
    if (adv) begin
      ps_r[4] <= ps_r[3];

      ps_r[5] <= ps_r[4];
      for (int p = 0; p < 4; p++) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          l1_r[p][ch] <= mix(rd_r[2*p][ch], rd_r[2*p+1][ch], {1'b0, ps_r[4].fr[0]});
        end
      end

      ps_r[6] <= ps_r[5];
      for (int b = 0; b < 2; b++) begin
        for (int ch = 0; ch < NUM_CH; ch++) begin
          l2_r[b][ch] <= mix(l1_r[2*b][ch], l1_r[2*b+1][ch], {1'b0, ps_r[5].fr[1]});
        end
      end

      ps_r[7] <= ps_r[6];
      for (int ch = 0; ch < NUM_CH; ch++) begin
        m_r[ch] <= mix(l2_r[0][ch], l2_r[1][ch], {1'b0, ps_r[6].fr[2]});
      end

      for (int ch = 0; ch < NUM_CH; ch++) begin
        out_r[ch] <= ps_r[7].bypass ? ps_r[7].pix[ch] : mix(ps_r[7].pix[ch], m_r[ch], k_str);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rgb   = out_r;

endmodule

`default_nettype wire

// ===== rtl/lut3d_trilinear_blend_unit.sv =====
// ============================================================================
// lut3d_trilinear_blend_unit - 3D color table lookup with strength blend
// Loads cube table entries, maps pixels through the table by trilinear
// interpolation and mixes the result with the original pixel.
//
//   channel  direction  handshake              word
//   in_      input      in_valid / in_ready    load entry or pixel
//   out_     output     out_valid / out_ready  mapped pixel (pixels only)
//   cfg_     input      cfg_valid / cfg_ready  register index and data
//
// One word is taken per cycle while the queue has room; a pixel passes
// through the queue, the 16-stage normalization divider, the index math,
// the table read and the interpolation stages before it appears.
// A load gives no output word. Reset clears all valid state and sets the
// configuration registers; table contents stay undefined until loaded.
// A stall at the output freezes the back; a two-word queue keeps in_ready
// free of a combinational path from out_ready.
// ============================================================================
`default_nettype none

module lut3d_trilinear_blend_unit #(
  parameter int MAX_LUT_POINTS = lut3d_pkg::MAX_LUT_POINTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_req_type,
  input  wire logic [lut3d_pkg::IDX_W-1:0]     in_entry_index,
  input  wire logic [lut3d_pkg::CHAN_W-1:0]    in_chan_red,
  input  wire logic [lut3d_pkg::CHAN_W-1:0]    in_chan_green,
  input  wire logic [lut3d_pkg::CHAN_W-1:0]    in_chan_blue,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [lut3d_pkg::CHAN_W-1:0]         out_red,
  output logic [lut3d_pkg::CHAN_W-1:0]         out_green,
  output logic [lut3d_pkg::CHAN_W-1:0]         out_blue,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [lut3d_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lut3d_pkg::DOM_W-1:0]     cfg_data
);
  import lut3d_pkg::*;

  cfg_t  cfg_r;
  logic  q_full;
  logic  push;
  qent_t push_data;
  logic  pop;
  logic  head_valid;
  qent_t head_data;
  rgb_t  out_rgb;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.en       <= 1'b0;
      cfg_r.size     <= SIZE_RST;
      cfg_r.strength <= STRENGTH_RST;
      cfg_r.dom_lo   <= '0;
      cfg_r.dom_hi   <= DOM_HIGH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_LUT_ENABLE:     cfg_r.en       <= cfg_data[0];
        REG_LUT_SIZE:       cfg_r.size     <= cfg_data[SIZE_W-1:0];
        REG_BLEND_STRENGTH: cfg_r.strength <= cfg_data[STR_W-1:0];
        REG_DOMAIN_LOW:     cfg_r.dom_lo   <= cfg_data;
        REG_DOMAIN_HIGH:    cfg_r.dom_hi   <= cfg_data;
        default: ;
      endcase
    end
  end

  lut3d_front #(
    .MAX_LUT_POINTS (MAX_LUT_POINTS)
  ) u_front (
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_entry_index (in_entry_index),
    .in_chan_red    (in_chan_red),
    .in_chan_green  (in_chan_green),
    .in_chan_blue   (in_chan_blue),
    .cfg            (cfg_r),
    .q_full         (q_full),
    .push           (push),
    .push_data      (push_data)
  );

  lut3d_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  lut3d_back #(
    .MAX_LUT_POINTS (MAX_LUT_POINTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_rgb    (out_rgb)
  );

  assign out_red   = out_rgb[0];
  assign out_green = out_rgb[1];
  assign out_blue  = out_rgb[2];

endmodule

`default_nettype wire
